@@ sv/swpd_pkg.sv @@
// ---------------------------------------------------------------------------
// swpd_pkg: shared types and constants of the sync word packet deframer
// Phase encoding, result kinds, register indexes, the result record and
// the checksum byte term.
// ---------------------------------------------------------------------------
package swpd_pkg;

    localparam int unsigned HEADER_BYTES = 18;
    localparam logic [31:0] SYNC_WORD_RESET = 32'hDEAD_BEEF;
    localparam logic SIGNED_SUM_RESET = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_SYNC_WORD  = 1'b0,
        REG_SIGNED_SUM = 1'b1
    } reg_idx_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        packet_end;
        logic [7:0]  channel_id;
        logic [7:0]  packet_kind;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [31:0] payload_length;
        logic [15:0] checksum_received;
        logic [15:0] checksum_computed;
    } out_item_t;

    // A byte as it enters the 16-bit sum: sign extended in signed mode.
    function automatic logic [15:0] byte_term(input logic [7:0] b, input logic sgn);
        logic [15:0] t;
        t = (sgn && b[7]) ? {8'hFF, b} : {8'h00, b};
        return t;
    endfunction

endpackage

@@ sv/sync_word_packet_deframer.sv @@
// ---------------------------------------------------------------------------
// sync_word_packet_deframer
// Hunts for a sync word in the received byte stream, parses the header,
// passes payload bytes out and checks the trailing 16-bit additive checksum.
// ---------------------------------------------------------------------------
//  Channel  Handshake                  Payload
//  in       in_valid / in_stall        rx_byte
//  out      out_valid / out_stall      kind .. checksum_computed
//  cfg      psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  One item is taken per clock while in_stall is low; each item updates the
//  parser state, and any result is registered into the output register.
//  A result register plus one skid entry let input continue while the
//  output is stalled; in_stall rises only when the skid entry is full.
//  Reset clears all parser state and loads the register defaults.
// ---------------------------------------------------------------------------
module sync_word_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic        packet_end,
    output logic [7:0]  channel_id,
    output logic [7:0]  packet_kind,
    output logic [31:0] source_addr,
    output logic [31:0] dest_addr,
    output logic [31:0] payload_length,
    output logic [15:0] checksum_received,
    output logic [15:0] checksum_computed,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [31:0] sync_word_reg;
    logic        signed_sum_reg;
    logic        cfg_write;
    swpd_pkg::reg_idx_t cfg_idx;

    // parser state
    swpd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] sync_window_reg, sync_window_next;
    logic [2:0]  window_fill_reg, window_fill_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  hdr_channel_reg, hdr_channel_next;
    logic [7:0]  hdr_type_reg, hdr_type_next;
    logic [31:0] hdr_source_reg, hdr_source_next;
    logic [31:0] hdr_dest_reg, hdr_dest_next;
    logic [31:0] hdr_length_reg, hdr_length_next;
    logic [7:0]  checksum_high_reg, checksum_high_next;

    // output register and skid entry
    logic                 out_valid_reg;
    swpd_pkg::out_item_t  out_item_reg;
    logic                 skid_valid_reg;
    swpd_pkg::out_item_t  skid_item_reg;

    logic                 in_accept;
    logic                 out_fire;
    logic                 res_valid;
    swpd_pkg::out_item_t  res_item;

    // decode helpers
    logic [31:0] window_shift;
    logic [31:0] length_shift;
    logic [31:0] count_inc;
    logic [15:0] term;
    logic [15:0] sum_add;
    logic [15:0] sync_sum;
    logic [15:0] rx_checksum;
    logic        sync_hit;
    logic        header_last;
    logic        payload_last;
    logic        check_high;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = swpd_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            swpd_pkg::REG_SYNC_WORD:  prdata = sync_word_reg;
            swpd_pkg::REG_SIGNED_SUM: prdata = {31'd0, signed_sum_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg  <= swpd_pkg::SYNC_WORD_RESET;
            signed_sum_reg <= swpd_pkg::SIGNED_SUM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                swpd_pkg::REG_SYNC_WORD:  sync_word_reg  <= pwdata;
                swpd_pkg::REG_SIGNED_SUM: signed_sum_reg <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    // ---------------- handshakes ----------------
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    // ---------------- decode helpers ----------------
    always_comb
    begin
        window_shift = {sync_window_reg[23:0], rx_byte};
        length_shift = {hdr_length_reg[23:0], rx_byte};
        count_inc    = byte_count_reg + 32'd1;
        term         = swpd_pkg::byte_term(rx_byte, signed_sum_reg);
        sum_add      = running_sum_reg + term;
        sync_sum     = swpd_pkg::byte_term(window_shift[31:24], signed_sum_reg)
                     + swpd_pkg::byte_term(window_shift[23:16], signed_sum_reg)
                     + swpd_pkg::byte_term(window_shift[15:8], signed_sum_reg)
                     + swpd_pkg::byte_term(window_shift[7:0], signed_sum_reg);
        rx_checksum  = {checksum_high_reg, rx_byte};
        // The window is full once this byte makes the fourth.
        sync_hit     = (window_fill_reg >= 3'd3) && (window_shift == sync_word_reg);
        header_last  = byte_count_reg == 32'(swpd_pkg::HEADER_BYTES - 1);
        payload_last = count_inc >= hdr_length_reg;
        check_high   = byte_count_reg == 32'd0;
    end

    // ---------------- phase sequencing ----------------
    always_comb
    begin
        phase_next = phase_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                swpd_pkg::PH_HUNT:
                    if (sync_hit)
                        phase_next = swpd_pkg::PH_HEADER;
                swpd_pkg::PH_HEADER:
                    if (header_last)
                        phase_next = (length_shift == 32'd0) ? swpd_pkg::PH_CHECK
                                                             : swpd_pkg::PH_PAYLOAD;
                swpd_pkg::PH_PAYLOAD:
                    if (payload_last)
                        phase_next = swpd_pkg::PH_CHECK;
                swpd_pkg::PH_CHECK:
                    if (!check_high)
                        phase_next = swpd_pkg::PH_HUNT;
                default:
                    phase_next = swpd_pkg::PH_HUNT;
            endcase
        end
    end

    // ---------------- datapath and result ----------------
    always_comb
    begin
        sync_window_next   = sync_window_reg;
        window_fill_next   = window_fill_reg;
        byte_count_next    = byte_count_reg;
        running_sum_next   = running_sum_reg;
        hdr_channel_next   = hdr_channel_reg;
        hdr_type_next      = hdr_type_reg;
        hdr_source_next    = hdr_source_reg;
        hdr_dest_next      = hdr_dest_reg;
        hdr_length_next    = hdr_length_reg;
        checksum_high_next = checksum_high_reg;

        res_valid                  = 1'b0;
        res_item                   = '0;
        res_item.channel_id        = hdr_channel_reg;
        res_item.packet_kind       = hdr_type_reg;
        res_item.source_addr       = hdr_source_reg;
        res_item.dest_addr         = hdr_dest_reg;
        res_item.payload_length    = hdr_length_reg;

        if (in_accept)
        begin
            unique case (phase_reg)
                swpd_pkg::PH_HUNT:
                begin
                    sync_window_next = window_shift;
                    if (window_fill_reg < 3'd4)
                        window_fill_next = window_fill_reg + 3'd1;
                    if (sync_hit)
                    begin
                        running_sum_next = sync_sum;
                        byte_count_next  = 32'd4;
                    end
                end
                swpd_pkg::PH_HEADER:
                begin
                    running_sum_next = sum_add;
                    if (byte_count_reg == 32'd4)
                        hdr_channel_next = rx_byte;
                    else if (byte_count_reg == 32'd5)
                        hdr_type_next = rx_byte;
                    else if (byte_count_reg >= 32'd6 && byte_count_reg <= 32'd9)
                        hdr_source_next = {hdr_source_reg[23:0], rx_byte};
                    else if (byte_count_reg >= 32'd10 && byte_count_reg <= 32'd13)
                        hdr_dest_next = {hdr_dest_reg[23:0], rx_byte};
                    else
                        hdr_length_next = length_shift;
                    byte_count_next = header_last ? 32'd0 : count_inc;
                end
                swpd_pkg::PH_PAYLOAD:
                begin
                    running_sum_next      = sum_add;
                    byte_count_next       = payload_last ? 32'd0 : count_inc;
                    res_valid             = 1'b1;
                    res_item.kind         = swpd_pkg::KIND_PAYLOAD;
                    res_item.payload_byte = rx_byte;
                end
                swpd_pkg::PH_CHECK:
                begin
                    if (check_high)
                    begin
                        checksum_high_next = rx_byte;
                        byte_count_next    = 32'd1;
                    end
                    else
                    begin
                        res_valid                  = 1'b1;
                        res_item.kind              = (rx_checksum == running_sum_reg)
                                                   ? swpd_pkg::KIND_GOOD
                                                   : swpd_pkg::KIND_ERROR;
                        res_item.packet_end        = 1'b1;
                        res_item.checksum_received = rx_checksum;
                        res_item.checksum_computed = running_sum_reg;
                        sync_window_next           = 32'd0;
                        window_fill_next           = 3'd0;
                        byte_count_next            = 32'd0;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= swpd_pkg::PH_HUNT;
            sync_window_reg   <= 32'd0;
            window_fill_reg   <= 3'd0;
            byte_count_reg    <= 32'd0;
            running_sum_reg   <= 16'd0;
            hdr_channel_reg   <= 8'd0;
            hdr_type_reg      <= 8'd0;
            hdr_source_reg    <= 32'd0;
            hdr_dest_reg      <= 32'd0;
            hdr_length_reg    <= 32'd0;
            checksum_high_reg <= 8'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            sync_window_reg   <= sync_window_next;
            window_fill_reg   <= window_fill_next;
            byte_count_reg    <= byte_count_next;
            running_sum_reg   <= running_sum_next;
            hdr_channel_reg   <= hdr_channel_next;
            hdr_type_reg      <= hdr_type_next;
            hdr_source_reg    <= hdr_source_next;
            hdr_dest_reg      <= hdr_dest_next;
            hdr_length_reg    <= hdr_length_next;
            checksum_high_reg <= checksum_high_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload side: the skid entry moves up first, then a new result.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_item_reg <= skid_item_reg;
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_item_reg <= res_item;
        end
        else if (res_valid)
        begin
            skid_item_reg <= res_item;
        end
    end

    assign out_valid         = out_valid_reg;
    assign kind              = out_item_reg.kind;
    assign payload_byte      = out_item_reg.payload_byte;
    assign packet_end        = out_item_reg.packet_end;
    assign channel_id        = out_item_reg.channel_id;
    assign packet_kind       = out_item_reg.packet_kind;
    assign source_addr       = out_item_reg.source_addr;
    assign dest_addr         = out_item_reg.dest_addr;
    assign payload_length    = out_item_reg.payload_length;
    assign checksum_received = out_item_reg.checksum_received;
    assign checksum_computed = out_item_reg.checksum_computed;

`ifndef ASSERT_OFF
    // The skid entry only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a result in the output register");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled while the output was not stalled");

    // Header bytes are counted from the fifth byte up to the last header byte.
    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == swpd_pkg::PH_HEADER) |->
            (byte_count_reg >= 32'd4 &&
             byte_count_reg < 32'(swpd_pkg::HEADER_BYTES)))
        else $error("header byte count out of range");

    a_window_fill: assert property (@(posedge clk) disable iff (!rst_n)
        window_fill_reg <= 3'd4)
        else $error("sync window fill count overran");
`endif

endmodule

@@ tb/sync_word_packet_deframer_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_word_packet_deframer_test: self-checking bench for the deframer
// A short stimulus table walks one packet through hunt, header, payload and
// trailer at the reset settings. Random framed packets, stray bytes and cut
// sync words follow under several register settings. Every item is run
// through a local model of the parser, and every result of the block is
// compared field by field in order. Both channels idle at random.
// ---------------------------------------------------------------------------
module sync_word_packet_deframer_test;

    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam int unsigned MAX_BODY = 40;

    typedef enum logic [1:0] {
        ROW_QUIET,  // no result may come from this item
        ROW_MODEL,  // result as the local model gives it
        ROW_KIND    // result kind typed in the row
    } row_check_t;

    typedef struct packed {
        logic [7:0]       rx;
        row_check_t       how;
        swpd_pkg::kind_t  k;
    } opening_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        packet_end;
    logic [7:0]  channel_id;
    logic [7:0]  packet_kind;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [31:0] payload_length;
    logic [15:0] checksum_received;
    logic [15:0] checksum_computed;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies and parser state of the local model.
    logic [31:0]      cfg_sync = swpd_pkg::SYNC_WORD_RESET;
    logic             cfg_signed_sum = swpd_pkg::SIGNED_SUM_RESET;
    swpd_pkg::phase_t st_phase = swpd_pkg::PH_HUNT;
    logic [31:0]      st_window = '0;
    logic [2:0]       st_fill = '0;
    logic [31:0]      st_count = '0;
    logic [15:0]      st_sum = '0;
    logic [7:0]       st_channel = '0;
    logic [7:0]       st_type = '0;
    logic [31:0]      st_source = '0;
    logic [31:0]      st_dest = '0;
    logic [31:0]      st_length = '0;
    logic [7:0]       st_ck_high = '0;

    swpd_pkg::out_item_t deframed_due[$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          calm_run = 1'b0;

    // One packet at reset settings: the signed sum of all header and payload
    // bytes is -77, so the trailer FF B3 is good.
    opening_row_t opening_rows [0:22] = '{
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hFF, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hDE, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hAD, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hBE, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hEF, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hFF, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hFF, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hFF, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hFF, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hFF, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h00, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h01, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'h7F, ROW_MODEL, swpd_pkg::KIND_PAYLOAD},
        '{8'hFF, ROW_QUIET, swpd_pkg::KIND_PAYLOAD},
        '{8'hB3, ROW_KIND,  swpd_pkg::KIND_GOOD}
    };

    sync_word_packet_deframer DUT (.*);

    always #6 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sync_word_packet_deframer regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [15:0] sum_term(input logic [7:0] b);
        return (cfg_signed_sum && b[7]) ? {8'hFF, b} : {8'h00, b};
    endfunction

    // Advances the model by one byte and returns the result it causes, if any.
    task automatic deframe_byte(input logic [7:0] b, output bit emits,
                                output swpd_pkg::out_item_t rec);
        logic [15:0] trailer;
        emits = 1'b0;
        rec = '0;
        case (st_phase)
            swpd_pkg::PH_HUNT:
            begin
                st_window = {st_window[23:0], b};
                if (st_fill < 3'd4)
                    st_fill++;
                if (st_fill >= 3'd4 && st_window == cfg_sync)
                begin
                    st_sum = sum_term(st_window[31:24]) + sum_term(st_window[23:16])
                           + sum_term(st_window[15:8]) + sum_term(st_window[7:0]);
                    st_count = 4;
                    st_phase = swpd_pkg::PH_HEADER;
                end
            end
            swpd_pkg::PH_HEADER:
            begin
                st_sum += sum_term(b);
                if (st_count == 4)
                    st_channel = b;
                else if (st_count == 5)
                    st_type = b;
                else if (st_count <= 9)
                    st_source = {st_source[23:0], b};
                else if (st_count <= 13)
                    st_dest = {st_dest[23:0], b};
                else
                    st_length = {st_length[23:0], b};
                st_count++;
                if (st_count >= swpd_pkg::HEADER_BYTES)
                begin
                    st_count = 0;
                    st_phase = (st_length == 0) ? swpd_pkg::PH_CHECK
                                                : swpd_pkg::PH_PAYLOAD;
                end
            end
            swpd_pkg::PH_PAYLOAD:
            begin
                st_sum += sum_term(b);
                st_count++;
                if (st_count >= st_length)
                begin
                    st_count = 0;
                    st_phase = swpd_pkg::PH_CHECK;
                end
                emits = 1'b1;
                rec.kind = swpd_pkg::KIND_PAYLOAD;
                rec.payload_byte = b;
            end
            default:
            begin
                if (st_count == 0)
                begin
                    st_ck_high = b;
                    st_count = 1;
                end
                else
                begin
                    trailer = {st_ck_high, b};
                    emits = 1'b1;
                    rec.kind = (trailer == st_sum) ? swpd_pkg::KIND_GOOD
                                                   : swpd_pkg::KIND_ERROR;
                    rec.packet_end = 1'b1;
                    rec.checksum_received = trailer;
                    rec.checksum_computed = st_sum;
                    st_phase = swpd_pkg::PH_HUNT;
                    st_window = '0;
                    st_fill = '0;
                    st_count = 0;
                end
            end
        endcase
        rec.channel_id = st_channel;
        rec.packet_kind = st_type;
        rec.source_addr = st_source;
        rec.dest_addr = st_dest;
        rec.payload_length = st_length;
    endtask

    task automatic send_byte(input logic [7:0] b, input row_check_t how = ROW_MODEL,
                             input swpd_pkg::kind_t typed = swpd_pkg::KIND_PAYLOAD);
        bit                  emits;
        swpd_pkg::out_item_t rec;
        if (!calm_run && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        deframe_byte(b, emits, rec);
        if (how == ROW_KIND)
        begin
            rec.kind = typed;
            deframed_due.insert(deframed_due.size(), rec);
        end
        else if (how == ROW_MODEL && emits)
            deframed_due.insert(deframed_due.size(), rec);
        items_sent++;
    endtask

    task automatic reg_write(input swpd_pkg::reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == swpd_pkg::REG_SYNC_WORD)
            cfg_sync = value;
        else
            cfg_signed_sum = value[0];
        @(posedge clk);
    endtask

    task automatic reg_check(input swpd_pkg::reg_idx_t idx, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_mismatch(idx == swpd_pkg::REG_SYNC_WORD ? "sync_word read"
                                                           : "signed_byte_sum read",
                            prdata, want);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // A byte that cannot take part in a sync match under the current word.
    function automatic logic [7:0] stray_byte();
        logic [7:0] x;
        do
            x = 8'($urandom_range(0, 255));
        while (x == cfg_sync[31:24] || x == cfg_sync[23:16] ||
               x == cfg_sync[15:8] || x == cfg_sync[7:0]);
        return x;
    endfunction

    function automatic logic [31:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 0;
        else if (r == 9)
            return $urandom_range(13, MAX_BODY);
        return $urandom_range(1, 12);
    endfunction

    // Sends sync, header and payload; the trailer follows only when the whole
    // payload fits in MAX_BODY bytes.
    task automatic send_frame(input logic [31:0] len, input bit corrupt);
        logic [7:0]  b;
        logic [15:0] sum;
        logic [15:0] trailer;
        int unsigned body;
        bit          sync_in_body;
        sum = '0;
        for (int k = 0; k < swpd_pkg::HEADER_BYTES; k++)
        begin
            if (k < 4)
                b = cfg_sync[31 - 8 * k -: 8];
            else if (k < 14)
                b = 8'($urandom_range(0, 255));
            else
                b = len[31 - 8 * (k - 14) -: 8];
            sum += sum_term(b);
            send_byte(b);
        end
        body = (len > MAX_BODY) ? MAX_BODY : len;
        sync_in_body = (body >= 4) && ($urandom_range(0, 3) == 0);
        for (int k = 0; k < body; k++)
        begin
            b = (sync_in_body && k < 4) ? cfg_sync[31 - 8 * k -: 8] : 8'($urandom);
            sum += sum_term(b);
            send_byte(b);
        end
        if (len <= MAX_BODY)
        begin
            trailer = corrupt ? sum ^ (16'h1 << $urandom_range(0, 15)) : sum;
            send_byte(trailer[15:8]);
            send_byte(trailer[7:0]);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (deframed_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_setting(input logic [31:0] sync, input bit sgn,
                               input int unsigned goal);
        logic [31:0] sgn_word;
        int unsigned stop;
        int unsigned cut;
        // Upper bits of the mode word are junk the block must ignore.
        sgn_word = $urandom;
        sgn_word[0] = sgn;
        reg_write(swpd_pkg::REG_SYNC_WORD, sync);
        reg_write(swpd_pkg::REG_SIGNED_SUM, sgn_word);
        reg_check(swpd_pkg::REG_SYNC_WORD, sync);
        reg_check(swpd_pkg::REG_SIGNED_SUM, {31'b0, sgn});
        stop = items_sent + goal;
        while (items_sent < stop)
        begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 5)) send_byte(stray_byte());
                1:
                begin
                    cut = $urandom_range(1, 3);
                    for (int k = 0; k < cut; k++)
                        send_byte(cfg_sync[31 - 8 * k -: 8]);
                    send_byte(stray_byte());
                end
                default: send_frame(pick_length(), $urandom_range(0, 3) == 0);
            endcase
        end
        // Ending on a whole packet leaves an empty window for the next setting.
        send_frame(pick_length(), 1'b0);
        drain();
    endtask

    initial
    begin : stall_gen
        forever
        begin
            @(posedge clk);
            if (!calm_run && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        swpd_pkg::out_item_t want;
        if (rst_n && $isunknown({out_valid, in_stall}))
            report_mismatch("handshake unknown", 32'({out_valid, in_stall}), 32'd0);
        if (rst_n && out_valid && !out_stall)
        begin
            if (deframed_due.size() == 0)
                report_mismatch("result with nothing due, kind", 32'(kind), 32'd0);
            else
            begin
                want = deframed_due.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", 32'(kind), 32'(want.kind));
                if (payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", 32'(payload_byte),
                                    32'(want.payload_byte));
                if (packet_end !== want.packet_end)
                    report_mismatch("packet_end", 32'(packet_end), 32'(want.packet_end));
                if (channel_id !== want.channel_id)
                    report_mismatch("channel_id", 32'(channel_id), 32'(want.channel_id));
                if (packet_kind !== want.packet_kind)
                    report_mismatch("packet_kind", 32'(packet_kind),
                                    32'(want.packet_kind));
                if (source_addr !== want.source_addr)
                    report_mismatch("source_addr", source_addr, want.source_addr);
                if (dest_addr !== want.dest_addr)
                    report_mismatch("dest_addr", dest_addr, want.dest_addr);
                if (payload_length !== want.payload_length)
                    report_mismatch("payload_length", payload_length, want.payload_length);
                if (checksum_received !== want.checksum_received)
                    report_mismatch("checksum_received", 32'(checksum_received),
                                    32'(want.checksum_received));
                if (checksum_computed !== want.checksum_computed)
                    report_mismatch("checksum_computed", 32'(checksum_computed),
                                    32'(want.checksum_computed));
            end
        end
    end

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_check(swpd_pkg::REG_SYNC_WORD, swpd_pkg::SYNC_WORD_RESET);
        reg_check(swpd_pkg::REG_SIGNED_SUM, {31'b0, swpd_pkg::SIGNED_SUM_RESET});

        foreach (opening_rows[i])
            send_byte(opening_rows[i].rx, opening_rows[i].how, opening_rows[i].k);
        drain();

        run_setting(32'h0000_0000, 1'b0, 40);
        run_setting(32'hFFFF_FFFF, 1'b1, 40);
        run_setting($urandom, 1'b0, 40);
        run_setting($urandom, 1'b1, 40);
        run_setting(swpd_pkg::SYNC_WORD_RESET, 1'b0, 40);

        calm_run = 1'b1;
        run_setting($urandom, 1'($urandom_range(0, 1)), 35);
        // Largest length: the block stays in the payload to the end of the run.
        send_frame(32'hFFFF_FFFF, 1'b0);
        drain();

        if (mismatches == 0)
            $display("sync_word_packet_deframer regression: pass");
        else
            $display("sync_word_packet_deframer regression: fail");
        $finish;
    end

endmodule
